FILE: design/hfdl_pkg.sv
package hfdl_pkg;

  // Field widths of the request and result items.
  localparam int FUNC_W   = 2;
  localparam int SAMPLE_W = 24;
  localparam int DELAY_W  = 28;
  localparam int CFG_W    = 32;

  // Function codes of a request.
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  // Datapath widths of the cubic evaluation.
  // The doubled coefficients stay below 2^27 in magnitude.
  localparam int COEF_W   = 28;
  // Horner partial results stay below 2^29 in magnitude.
  localparam int HORNER_W = 30;
  // Width of the final sum before saturation.
  localparam int RES_W    = 32;

  // Saturation limits of a Q1.23 sample.
  localparam logic signed [RES_W-1:0] S24_MAX = 32'sd8388607;
  localparam logic signed [RES_W-1:0] S24_MIN = -32'sd8388608;

  // Status that the back end reports to the front end.
  typedef struct packed {
    logic init_clear;
    logic sweep;
  } back_stat_t;

endpackage

FILE: design/hermite_fractional_delay_line.sv
// Channel   Handshake                   Payload
// request   start / busy                in_func, in_sample_in, in_delay
// result    out_strobe (one cycle)      out_sample_out, out_saturated
// config    psel/penable/pwrite/pready  paddr, pwdata, prdata (min_delay at 0)
//
// In the back end a write is stored as it is popped. A read pops, then makes the 4 tap
// reads from the single-port store, forms the coefficients, runs three multiply and
// round steps and saturates; the result strobe follows in the next cycle.
// A clear pops, then zeroes the whole store, one entry per cycle.
// After reset the store is swept to zero with busy high.
// A two-entry queue sits between the front and back ends; busy rises when it is full.
// The result receiver cannot stall; each result is a single-cycle strobe.
module hermite_fractional_delay_line #(
  parameter int CAPACITY  = 4096,
  parameter int FRAC_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [hfdl_pkg::FUNC_W-1:0]          in_func,
  input  logic signed [hfdl_pkg::SAMPLE_W-1:0] in_sample_in,
  input  logic [hfdl_pkg::DELAY_W-1:0]         in_delay,
  output logic                                 out_strobe,
  output logic signed [hfdl_pkg::SAMPLE_W-1:0] out_sample_out,
  output logic                                 out_saturated,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [0:0]                           paddr,
  input  logic [hfdl_pkg::CFG_W-1:0]           pwdata,
  output logic [hfdl_pkg::CFG_W-1:0]           prdata,
  output logic                                 pready
);

  import hfdl_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int QW = FUNC_W + AW + SAMPLE_W + FRAC_BITS;
  localparam logic [DELAY_W-1:0] MIN_DELAY_RESET = DELAY_W'(2) << FRAC_BITS;

  logic [DELAY_W-1:0] min_delay_r;
  logic               q_push;
  logic [QW-1:0]      q_wdata;
  logic               q_pop;
  logic               q_valid;
  logic               q_full;
  logic [QW-1:0]      q_rdata;
  back_stat_t         stat;

  // Minimum delay register.
  assign pready = 1'b1;
  assign prdata = (paddr == 1'b0) ? CFG_W'(min_delay_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_delay_r <= MIN_DELAY_RESET;
    end else if (psel && penable && pwrite && pready && (paddr == 1'b0)) begin
      min_delay_r <= pwdata[DELAY_W-1:0];
    end
  end

  hfdl_front #(
    .CAPACITY  (CAPACITY),
    .FRAC_BITS (FRAC_BITS),
    .QW        (QW)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_func      (in_func),
    .in_sample_in (in_sample_in),
    .in_delay     (in_delay),
    .min_delay    (min_delay_r),
    .stat         (stat),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_wdata      (q_wdata)
  );

  hfdl_queue #(
    .W (QW)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .valid (q_valid),
    .full  (q_full),
    .rdata (q_rdata)
  );

  hfdl_back #(
    .CAPACITY  (CAPACITY),
    .FRAC_BITS (FRAC_BITS),
    .QW        (QW)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_data         (q_rdata),
    .q_pop          (q_pop),
    .stat           (stat),
    .out_strobe     (out_strobe),
    .out_sample_out (out_sample_out),
    .out_saturated  (out_saturated)
  );

endmodule

FILE: design/hfdl_queue.sv
module hfdl_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic         valid,
  output logic         full,
  output logic [W-1:0] rdata
);

  logic [W-1:0] ent_r [2];
  logic         wr_ptr_r;
  logic         rd_ptr_r;
  logic [1:0]   cnt_r;

  assign valid = (cnt_r != 2'd0);
  assign full  = (cnt_r == 2'd2);
  assign rdata = ent_r[rd_ptr_r];

  // Pointers and fill count of the two-entry queue.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= wdata;
    end
  end

  // The front end never pushes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("request pushed into a full queue");

  // The back end never pops an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> valid)
    else $error("request popped from an empty queue");

endmodule

FILE: design/hfdl_front.sv
module hfdl_front #(
  parameter int CAPACITY  = 4096,
  parameter int FRAC_BITS = 16,
  parameter int QW        = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [hfdl_pkg::FUNC_W-1:0]    in_func,
  input  logic signed [hfdl_pkg::SAMPLE_W-1:0] in_sample_in,
  input  logic [hfdl_pkg::DELAY_W-1:0]   in_delay,
  input  logic [hfdl_pkg::DELAY_W-1:0]   min_delay,
  input  hfdl_pkg::back_stat_t           stat,
  input  logic                           q_full,
  output logic                           q_push,
  output logic [QW-1:0]                  q_wdata
);

  import hfdl_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int IW = DELAY_W - FRAC_BITS;

  logic [AW-1:0]        wp_r;
  logic [AW-1:0]        wp_nxt;
  logic                 accept;
  logic [DELAY_W-1:0]   d_clamped;
  logic [IW+AW-1:0]     d_int_ext;
  logic [AW-1:0]        d_int;
  logic [AW-1:0]        entry_addr;

  // Requests wait while the queue is full or the store is swept after reset.
  assign busy   = q_full | stat.init_clear;
  assign accept = start & ~busy;

  // Clamp the delay and take its integer part modulo the store depth.
  assign d_clamped = (in_delay < min_delay) ? min_delay : in_delay;
  assign d_int_ext = (IW + AW)'(d_clamped[DELAY_W-1:FRAC_BITS]);
  assign d_int     = d_int_ext[AW-1:0];

  // A write goes at the write pointer; a read starts its window at wp - D - 2.
  always_comb begin
    entry_addr = wp_r;
    wp_nxt     = wp_r;
    q_push     = 1'b0;
    case (in_func)
      FUNC_WRITE: begin
        q_push = accept;
        if (accept) begin
          wp_nxt = wp_r + AW'(1);
        end
      end
      FUNC_READ: begin
        q_push     = accept;
        entry_addr = wp_r - d_int - AW'(2);
      end
      FUNC_CLEAR: begin
        q_push = accept;
        if (accept) begin
          wp_nxt = '0;
        end
      end
      default: begin
        q_push = 1'b0;
      end
    endcase
  end

  assign q_wdata = {in_func, entry_addr, in_sample_in, d_clamped[FRAC_BITS-1:0]};

  // Write pointer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
    end else begin
      wp_r <= wp_nxt;
    end
  end

  // The post-reset clear is always a sweep of the store.
  a_init_is_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    stat.init_clear |-> stat.sweep)
    else $error("post-reset clear flag set outside a sweep");

endmodule

FILE: design/hfdl_back.sv
module hfdl_back #(
  parameter int CAPACITY  = 4096,
  parameter int FRAC_BITS = 16,
  parameter int QW        = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 q_valid,
  input  logic [QW-1:0]                        q_data,
  output logic                                 q_pop,
  output hfdl_pkg::back_stat_t                 stat,
  output logic                                 out_strobe,
  output logic signed [hfdl_pkg::SAMPLE_W-1:0] out_sample_out,
  output logic                                 out_saturated
);

  import hfdl_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int PW = HORNER_W + FRAC_BITS + 1;
  localparam int SW = PW + 1;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_TAP   = 3'd2;
  localparam logic [2:0] ST_COEF  = 3'd3;
  localparam logic [2:0] ST_MUL   = 3'd4;
  localparam logic [2:0] ST_ADD   = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  localparam logic signed [SW-1:0] HALF_LSB = SW'(1) <<< (FRAC_BITS - 1);

  logic [2:0]                  state_r;
  logic [2:0]                  state_nxt;
  logic                        init_r;
  logic [AW-1:0]               sweep_r;
  logic [2:0]                  tap_cnt_r;
  logic [1:0]                  round_r;
  logic [AW-1:0]               base_r;
  logic [FRAC_BITS-1:0]        frac_r;

  logic [SAMPLE_W-1:0]         mem [CAPACITY];
  logic                        mem_we;
  logic [AW-1:0]               mem_addr;
  logic [SAMPLE_W-1:0]         mem_wd;
  logic signed [SAMPLE_W-1:0]  rd_r;
  logic signed [SAMPLE_W-1:0]  tap_r [4];

  logic signed [COEF_W-1:0]    xm1;
  logic signed [COEF_W-1:0]    x0;
  logic signed [COEF_W-1:0]    x1;
  logic signed [COEF_W-1:0]    x2;
  logic signed [COEF_W-1:0]    d01;
  logic signed [COEF_W-1:0]    c1_r;
  logic signed [COEF_W-1:0]    c2_r;
  logic signed [COEF_W-1:0]    c3_r;

  logic signed [HORNER_W-1:0]  mul_a;
  logic signed [FRAC_BITS:0]   mul_t;
  logic signed [PW-1:0]        mul_full;
  logic signed [PW-1:0]        prod_r;
  logic signed [SW-1:0]        addend;
  logic signed [SW-1:0]        sum;
  logic signed [SW-1:0]        sum_shr;
  logic signed [HORNER_W-1:0]  acc_r;

  logic signed [RES_W-1:0]     res;
  logic                        res_hi;
  logic                        res_lo;
  logic                        out_strobe_r;
  logic signed [SAMPLE_W-1:0]  out_sample_r;
  logic                        out_sat_r;

  logic [FUNC_W-1:0]           q_op;
  logic [AW-1:0]               q_addr;
  logic [SAMPLE_W-1:0]         q_sample;
  logic [FRAC_BITS-1:0]        q_frac;

  // Fields of the queue head.
  assign {q_op, q_addr, q_sample, q_frac} = q_data;

  assign stat.init_clear = init_r;
  assign stat.sweep      = (state_r == ST_CLEAR);

  // Sequencer: store port control and next state.
  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = q_addr;
    mem_wd    = q_sample;
    case (state_r)
      ST_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = sweep_r;
        mem_wd   = '0;
        if (&sweep_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_op)
            FUNC_WRITE: mem_we = 1'b1;
            FUNC_READ:  state_nxt = ST_TAP;
            FUNC_CLEAR: state_nxt = ST_CLEAR;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_TAP: begin
        mem_addr = base_r + AW'(tap_cnt_r[1:0]);
        if (tap_cnt_r == 3'd4) begin
          state_nxt = ST_COEF;
        end
      end
      ST_COEF: state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_ADD;
      ST_ADD: begin
        if (round_r == 2'd2) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_MUL;
        end
      end
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sample store, one port, registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wd;
    end
    rd_r <= mem[mem_addr];
  end

  // Doubled coefficients from the four taps.
  assign xm1 = COEF_W'(tap_r[0]);
  assign x0  = COEF_W'(tap_r[1]);
  assign x1  = COEF_W'(tap_r[2]);
  assign x2  = COEF_W'(tap_r[3]);
  assign d01 = x0 - x1;

  // Shared multiplier and rounding adder of the Horner steps.
  assign mul_a    = (round_r == 2'd0) ? HORNER_W'(c3_r) : acc_r;
  assign mul_t    = $signed({1'b0, frac_r});
  assign mul_full = mul_a * mul_t;

  always_comb begin
    case (round_r)
      2'd0:    addend = SW'(c2_r) <<< FRAC_BITS;
      2'd1:    addend = SW'(c1_r) <<< FRAC_BITS;
      default: addend = '0;
    endcase
  end

  assign sum     = SW'(prod_r) + addend + HALF_LSB;
  assign sum_shr = sum >>> FRAC_BITS;

  // Final halving with rounding, then saturation to 24 bits.
  assign res    = (RES_W'(acc_r) + (RES_W'(tap_r[1]) <<< 1) + RES_W'(1)) >>> 1;
  assign res_hi = (res > S24_MAX);
  assign res_lo = (res < S24_MIN);

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      init_r       <= 1'b1;
      sweep_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= (state_r == ST_DONE);
      if (state_r == ST_CLEAR) begin
        sweep_r <= sweep_r + AW'(1);
        if (&sweep_r) begin
          init_r <= 1'b0;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        tap_cnt_r <= 3'd0;
        base_r    <= q_addr;
        frac_r    <= q_frac;
      end
      ST_TAP: begin
        tap_cnt_r <= tap_cnt_r + 3'd1;
        if (tap_cnt_r != 3'd0) begin
          tap_r[0] <= tap_r[1];
          tap_r[1] <= tap_r[2];
          tap_r[2] <= tap_r[3];
          tap_r[3] <= rd_r;
        end
      end
      ST_COEF: begin
        round_r <= 2'd0;
        c1_r    <= x1 - xm1;
        c2_r    <= (xm1 <<< 1) - (x0 <<< 2) - x0 + (x1 <<< 2) - x2;
        c3_r    <= x2 - xm1 + d01 + (d01 <<< 1);
      end
      ST_MUL: begin
        prod_r <= mul_full;
      end
      ST_ADD: begin
        acc_r   <= sum_shr[HORNER_W-1:0];
        round_r <= round_r + 2'd1;
      end
      ST_DONE: begin
        out_sat_r <= res_hi | res_lo;
        if (res_hi) begin
          out_sample_r <= S24_MAX[SAMPLE_W-1:0];
        end else if (res_lo) begin
          out_sample_r <= S24_MIN[SAMPLE_W-1:0];
        end else begin
          out_sample_r <= res[SAMPLE_W-1:0];
        end
      end
      default: begin
        round_r <= round_r;
      end
    endcase
  end

  assign out_strobe     = out_strobe_r;
  assign out_sample_out = out_sample_r;
  assign out_saturated  = out_sat_r;

  // Results are pulses: a strobe is never directly followed by another one.
  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for two cycles");

  // Nothing can be queued while the post-reset sweep runs.
  a_init_queue_empty: assert property (@(posedge clk) disable iff (!rst_n)
    init_r |-> !q_valid)
    else $error("request queued during post-reset sweep");

endmodule

FILE: test/hermite_fractional_delay_line_test.sv
`timescale 1ns / 1ps

module hermite_fractional_delay_line_test;
  import hfdl_pkg::*;

  localparam int CAP = 4096;
  localparam int FRAC = 16;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam logic [0:0] MIN_DELAY_ADDR = 1'b0;
  // A clear walks the whole store; three of them may be in flight at once.
  localparam int SETTLE_CYCLES = 3 * CAP + 64;
  localparam int TAIL_CYCLES = 64;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic signed [SAMPLE_W-1:0] FULL_POS = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] FULL_NEG = 24'sh800000;

  typedef struct packed {
    logic [FUNC_W-1:0]          func;
    logic signed [SAMPLE_W-1:0] sample;
    logic [DELAY_W-1:0]         delay;
  } line_request_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       saturated;
  } tap_sum_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [FUNC_W-1:0] in_func = '0;
  logic signed [SAMPLE_W-1:0] in_sample_in = '0;
  logic [DELAY_W-1:0] in_delay = '0;
  logic out_strobe;
  logic signed [SAMPLE_W-1:0] out_sample_out;
  logic out_saturated;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [0:0] paddr = '0;
  logic [CFG_W-1:0] pwdata = '0;
  logic [CFG_W-1:0] prdata;
  logic pready;

  // Mirror of the delay line state.
  int sample_mirror [CAP];
  logic [11:0] write_ptr_mirror = '0;
  logic [DELAY_W-1:0] min_delay_mirror = 28'd131072;

  line_request_t line_requests [$];
  tap_sum_t interp_due [$];
  int issued_count = 0;
  int accepted_count = 0;
  int send_idle_pct = 0;
  int fault_count = 0;
  int cycle_count = 0;

  hermite_fractional_delay_line dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_sample_in(in_sample_in), .in_delay(in_delay),
    .out_strobe(out_strobe), .out_sample_out(out_sample_out),
    .out_saturated(out_saturated),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Catmull-Rom cubic over the four taps around the delayed position.
  function automatic tap_sum_t interpolate_at(input logic [DELAY_W-1:0] delay);
    logic [DELAY_W-1:0] d;
    logic [11:0] base;
    longint xm1, x0, x1, x2, c1, c2, c3, t, a, b, c, r;
    tap_sum_t res;
    d = (delay < min_delay_mirror) ? min_delay_mirror : delay;
    base = write_ptr_mirror - d[DELAY_W-1:FRAC] - 12'd2;
    t = {48'd0, d[FRAC-1:0]};
    xm1 = sample_mirror[base];
    x0 = sample_mirror[12'(base + 12'd1)];
    x1 = sample_mirror[12'(base + 12'd2)];
    x2 = sample_mirror[12'(base + 12'd3)];
    c1 = x1 - xm1;
    c2 = 2 * xm1 - 5 * x0 + 4 * x1 - x2;
    c3 = x2 - xm1 + 3 * (x0 - x1);
    // Each Horner stage rounds half up on the way back from the fraction scale.
    a = (c3 * t + c2 * 65536 + 32768) >>> FRAC;
    b = (a * t + c1 * 65536 + 32768) >>> FRAC;
    c = (b * t + 32768) >>> FRAC;
    r = (c + 2 * x0 + 1) >>> 1;
    res.saturated = 1'b0;
    if (r > 64'sd8388607) begin
      r = 64'sd8388607;
      res.saturated = 1'b1;
    end
    if (r < -64'sd8388608) begin
      r = -64'sd8388608;
      res.saturated = 1'b1;
    end
    res.sample = r[SAMPLE_W-1:0];
    return res;
  endfunction

  // Update the mirror with one accepted request.
  task automatic apply_request(input line_request_t req);
    case (req.func)
      FUNC_WRITE: begin
        sample_mirror[write_ptr_mirror] = {{8{req.sample[SAMPLE_W-1]}}, req.sample};
        write_ptr_mirror = write_ptr_mirror + 12'd1;
      end
      FUNC_READ: begin
        interp_due.push_back(interpolate_at(req.delay));
      end
      FUNC_CLEAR: begin
        foreach (sample_mirror[i]) sample_mirror[i] = 0;
        write_ptr_mirror = '0;
      end
      default: begin
      end
    endcase
  endtask

  // Request driver.
  always @(posedge clk) begin : drive_requests
    line_request_t req;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        apply_request({in_func, in_sample_in, in_delay});
        accepted_count++;
      end
      if (!(start && busy)) begin
        if (line_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req = line_requests.pop_front();
          start <= 1'b1;
          in_func <= req.func;
          in_sample_in <= req.sample;
          in_delay <= req.delay;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Result checker.
  always @(posedge clk) begin : check_results
    tap_sum_t want;
    if (rst_n && out_strobe) begin
      if (interp_due.size() == 0) begin
        if (fault_count < 10)
          $display("unexpected result: sample %0d saturated %0b",
                   out_sample_out, out_saturated);
        fault_count++;
      end else begin
        want = interp_due.pop_front();
        if (out_sample_out !== want.sample || out_saturated !== want.saturated) begin
          if (fault_count < 10)
            $display("result mismatch: sample %0d/%0d saturated %0b/%0b (expected/actual)",
                     want.sample, out_sample_out, want.saturated, out_saturated);
          fault_count++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("hermite_fractional_delay_line_test failed");
      $finish;
    end
  end

  task automatic post_request(input logic [FUNC_W-1:0] func,
                              input logic signed [SAMPLE_W-1:0] sample,
                              input logic [DELAY_W-1:0] delay);
    line_requests.push_back({func, sample, delay});
    issued_count++;
  endtask

  // Wait until every request is taken and every read has answered.
  task automatic wait_drained();
    while (accepted_count != issued_count || interp_due.size() != 0) @(posedge clk);
  endtask

  // Let any clear still in flight finish, then write the minimum delay.
  task automatic write_min_delay(input logic [DELAY_W-1:0] value);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= MIN_DELAY_ADDR;
    pwdata <= {{(CFG_W - DELAY_W){1'b0}}, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    min_delay_mirror = value;
  endtask

  // Mostly writes and reads near the write pointer, with clears and unused codes mixed in.
  task automatic post_random(input int count);
    int n;
    int sel;
    logic signed [SAMPLE_W-1:0] s;
    logic [DELAY_W-1:0] d;
    n = 0;
    while (n < count) begin
      sel = $urandom_range(99);
      if (sel < 46) begin
        if ($urandom_range(99) < 15) s = $urandom_range(1) ? FULL_POS : FULL_NEG;
        else s = SAMPLE_W'($urandom);
        post_request(FUNC_WRITE, s, DELAY_W'($urandom));
        n++;
      end else if (sel < 94) begin
        if ($urandom_range(99) < 75) d = {12'($urandom_range(40)), 16'($urandom)};
        else d = DELAY_W'($urandom);
        post_request(FUNC_READ, SAMPLE_W'($urandom), d);
        n++;
      end else if (sel < 96) begin
        post_request(FUNC_CLEAR, SAMPLE_W'($urandom), DELAY_W'($urandom));
        n++;
      end else begin
        post_request(FUNC_UNUSED, SAMPLE_W'($urandom), DELAY_W'($urandom));
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    write_min_delay(28'd131072);
    send_idle_pct = 10;
    // Full-scale samples in alternating pairs make the cubic overshoot both rails.
    post_request(FUNC_WRITE, FULL_POS, '0);
    post_request(FUNC_WRITE, FULL_NEG, '0);
    post_request(FUNC_WRITE, FULL_NEG, '0);
    post_request(FUNC_WRITE, FULL_POS, '0);
    post_request(FUNC_WRITE, FULL_POS, '0);
    post_request(FUNC_WRITE, FULL_NEG, '0);
    post_request(FUNC_READ, '0, 28'h0000000);
    post_request(FUNC_READ, '0, 28'h0028000);
    post_request(FUNC_READ, '0, 28'h0048000);
    post_request(FUNC_READ, '0, 28'h002FFFF);
    post_request(FUNC_READ, '0, 28'hFFFFFFF);
    post_request(FUNC_READ, '0, 28'h001FFFF);
    post_request(FUNC_UNUSED, FULL_POS, 28'hFFFFFFF);
    post_request(FUNC_CLEAR, '0, '0);
    post_request(FUNC_READ, '0, 28'h0030000);
    post_request(FUNC_WRITE, 24'sh123456, '0);
    post_request(FUNC_WRITE, -24'sd1, '0);
    post_request(FUNC_READ, '0, 28'h0024000);
    post_request(FUNC_READ, '0, 28'h0010000);
    post_random(130);

    // Largest minimum: every read lands on the farthest tap window.
    write_min_delay(28'hFFFFFFF);
    post_random(40);

    // No minimum: the newest tap wraps onto the slot about to be written.
    write_min_delay(28'd0);
    send_idle_pct = 75;
    post_random(80);

    write_min_delay(DELAY_W'($urandom_range(12 << FRAC, 2 << FRAC)));
    send_idle_pct = 0;
    post_random(80);

    write_min_delay(28'h0018000);
    post_random(50);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fault_count == 0 && interp_due.size() == 0) begin
      $display("hermite_fractional_delay_line_test passed");
    end else begin
      $display("hermite_fractional_delay_line_test failed");
    end
    $finish;
  end

endmodule
